// ===== sv/srs_pkg.sv =====
// Shared types and constants for the searched range set.
`timescale 1ns / 1ps
package srs_pkg;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int POS_BITS_DEF    = 48;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_SHIFT = 2'd1,
        CELL_LOAD  = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op a_op;
        t_cell_op b_op;
    } t_chain_ctl;
endpackage

// ===== sv/srs_cell.sv =====
// One table cell: holds a range, takes its neighbor's range or a loaded range.
`timescale 1ns / 1ps
module srs_cell #(
    parameter int POS_BITS = 48
) (
    input  logic                 i_clk,
    input  srs_pkg::t_cell_op    i_op,
    input  logic [POS_BITS-1:0]  i_next_start,
    input  logic [POS_BITS-1:0]  i_next_end,
    input  logic [POS_BITS-1:0]  i_load_start,
    input  logic [POS_BITS-1:0]  i_load_end,
    output logic [POS_BITS-1:0]  o_start,
    output logic [POS_BITS-1:0]  o_end
);
    import srs_pkg::*;

    logic [POS_BITS-1:0] r_start;
    logic [POS_BITS-1:0] r_end;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            CELL_SHIFT: begin
                r_start <= i_next_start;
                r_end   <= i_next_end;
            end
            CELL_LOAD: begin
                r_start <= i_load_start;
                r_end   <= i_load_end;
            end
            default: begin
                r_start <= r_start;
                r_end   <= r_end;
            end
        endcase
    end

    assign o_start = r_start;
    assign o_end   = r_end;
endmodule

// ===== sv/srs_ctrl.sv =====
// Sequencer: walks the cell chain for mark merging and gap queries.
`timescale 1ns / 1ps
module srs_ctrl #(
    parameter int TABLE_DEPTH = 16,
    parameter int POS_BITS    = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_func,
    input  logic [POS_BITS-1:0]  i_range_start,
    input  logic [POS_BITS-1:0]  i_range_end,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [POS_BITS-1:0]  o_gap_start,
    output logic [POS_BITS-1:0]  o_gap_end,
    output logic                 o_gap_valid,
    output logic                 o_last_result,
    output logic                 o_table_overflow,
    input  logic [POS_BITS-1:0]  i_a0_start,
    input  logic [POS_BITS-1:0]  i_a0_end,
    input  logic [POS_BITS-1:0]  i_a1_start,
    input  logic [POS_BITS-1:0]  i_a1_end,
    output srs_pkg::t_chain_ctl  o_ctl,
    output logic [POS_BITS-1:0]  o_b_start,
    output logic [POS_BITS-1:0]  o_b_end
);
    import srs_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int MW = $clog2(TABLE_DEPTH + 2);
    localparam logic [MW-1:0] DEP_M  = MW'(TABLE_DEPTH);
    localparam logic [CW-1:0] LAST_J = CW'(TABLE_DEPTH - 1);
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MWALK  = 8'b0000_0010,
        ST_MFLUSH = 8'b0000_0100,
        ST_MLOAD  = 8'b0000_1000,
        ST_MALIGN = 8'b0001_0000,
        ST_MDONE  = 8'b0010_0000,
        ST_QWALK  = 8'b0100_0000,
        ST_QEND   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [POS_BITS-1:0] r_s, n_s, r_e, n_e;
    logic [CW-1:0] r_cnt, n_cnt, r_j, n_j;
    logic [MW-1:0] r_mc, n_mc;
    logic r_ins, n_ins, r_hv, n_hv, r_ovf, n_ovf, r_done, n_done, r_pgv, n_pgv;
    logic [POS_BITS-1:0] r_ps, n_ps, r_pe, n_pe, r_ns, n_ns, r_pgs, n_pgs, r_pge, n_pge;
    logic r_ov, n_ov, r_ogv, n_ogv, r_olast, n_olast, r_oovf, n_oovf;
    logic [POS_BITS-1:0] r_ogs, n_ogs, r_oge, n_oge;

    logic can_push, accept, take_new, touch, cond0, cond1, skip;
    logic [POS_BITS-1:0] xa, xb, gap_e;

    assign can_push = !r_ov || !i_out_stall;
    assign accept   = (r_state == ST_IDLE) && i_in_valid;
    assign take_new = !r_ins && ((r_j == r_cnt) || (i_a0_start > r_s) ||
                      ((i_a0_start == r_s) && (i_a0_end > r_e)));
    assign xa       = take_new ? r_s : i_a0_start;
    assign xb       = take_new ? r_e : i_a0_end;
    assign touch    = (xa == '0) || ((xa - POS_ONE) <= r_pe);
    assign cond0    = (i_a0_start < r_s) || ((i_a0_start == r_s) && (i_a0_end <= r_e));
    assign cond1    = (i_a1_start < r_s) || ((i_a1_start == r_s) && (i_a1_end <= r_e));
    assign skip     = cond0 && cond1 && (({1'b0, r_j} + 1'b1) < {1'b0, r_cnt});
    assign gap_e    = (i_a0_start < r_e) ? i_a0_start : r_e;

    always_comb begin
        n_state = r_state;
        n_s = r_s;   n_e = r_e;   n_cnt = r_cnt; n_j = r_j;  n_mc = r_mc;
        n_ins = r_ins; n_hv = r_hv; n_ovf = r_ovf; n_done = r_done; n_pgv = r_pgv;
        n_ps = r_ps; n_pe = r_pe; n_ns = r_ns; n_pgs = r_pgs; n_pge = r_pge;
        n_ov = r_ov && i_out_stall;
        n_ogs = r_ogs; n_oge = r_oge; n_ogv = r_ogv; n_olast = r_olast; n_oovf = r_oovf;
        o_ctl.a_op = CELL_HOLD;
        o_ctl.b_op = CELL_HOLD;
        o_b_start  = r_ps;
        o_b_end    = r_pe;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_s = i_range_start; n_e = i_range_end; n_ns = i_range_start;
                    n_j = '0; n_mc = '0; n_ins = 1'b0; n_hv = 1'b0; n_ovf = 1'b0;
                    n_done = 1'b0; n_pgv = 1'b0;
                    if (i_func)
                        n_state = ST_QWALK;
                    else if (i_range_start <= i_range_end)
                        n_state = ST_MWALK;
                    else
                        n_state = ST_MDONE;
                end
            end
            ST_MWALK: begin
                if ((r_j == r_cnt) && r_ins) begin
                    n_state = ST_MFLUSH;
                end else begin
                    if (take_new) begin
                        n_ins = 1'b1;
                    end else begin
                        o_ctl.a_op = CELL_SHIFT;
                        n_j = r_j + 1'b1;
                    end
                    if (!r_hv) begin
                        n_hv = 1'b1; n_ps = xa; n_pe = xb; n_mc = MW'(1);
                    end else if (touch && (r_pe < xb)) begin
                        n_pe = xb;
                    end else if (!((xa >= r_ps) && (xb <= r_pe))) begin
                        if (r_mc <= DEP_M)
                            o_ctl.b_op = CELL_SHIFT;
                        n_ps = xa; n_pe = xb; n_mc = r_mc + 1'b1;
                    end
                end
            end
            ST_MFLUSH: begin
                if (r_mc <= DEP_M) begin
                    o_ctl.b_op = CELL_SHIFT;
                    n_state = ST_MLOAD;
                end else begin
                    n_ovf = 1'b1;
                    n_state = ST_MDONE;
                end
            end
            ST_MLOAD: begin
                o_ctl.a_op = CELL_LOAD;
                n_cnt = CW'(r_mc);
                n_j = '0;
                n_state = ST_MALIGN;
            end
            ST_MALIGN: begin
                if (MW'(r_j) == (DEP_M - r_mc)) begin
                    n_state = ST_MDONE;
                end else begin
                    o_ctl.a_op = CELL_SHIFT;
                    n_j = r_j + 1'b1;
                end
            end
            ST_MDONE: begin
                if (can_push) begin
                    n_ov = 1'b1; n_ogs = '0; n_oge = '0; n_ogv = 1'b0;
                    n_olast = 1'b1; n_oovf = r_ovf;
                    n_state = ST_IDLE;
                end
            end
            ST_QWALK: begin
                if (can_push) begin
                    o_ctl.a_op = CELL_SHIFT;
                    n_j = r_j + 1'b1;
                    if (r_j == LAST_J)
                        n_state = ST_QEND;
                    if ((r_j < r_cnt) && !skip && !r_done && (r_ns < r_e)) begin
                        if (r_ns < i_a0_start) begin
                            if (r_pgv) begin
                                n_ov = 1'b1; n_ogs = r_pgs; n_oge = r_pge; n_ogv = 1'b1;
                                n_olast = 1'b0; n_oovf = 1'b0;
                            end
                            n_pgv = 1'b1; n_pgs = r_ns; n_pge = gap_e;
                        end
                        if (r_ns <= i_a0_end) begin
                            if (i_a0_end == POS_MAX)
                                n_done = 1'b1;
                            else
                                n_ns = i_a0_end + POS_ONE;
                        end
                    end
                end
            end
            ST_QEND: begin
                if (can_push) begin
                    if (!r_done && (r_ns < r_e)) begin
                        if (r_pgv) begin
                            n_ov = 1'b1; n_ogs = r_pgs; n_oge = r_pge; n_ogv = 1'b1;
                            n_olast = 1'b0; n_oovf = 1'b0;
                        end
                        n_pgv = 1'b1; n_pgs = r_ns; n_pge = r_e; n_done = 1'b1;
                    end else begin
                        n_ov = 1'b1; n_ogv = r_pgv; n_olast = 1'b1; n_oovf = 1'b0;
                        n_ogs = r_pgv ? r_pgs : '0;
                        n_oge = r_pgv ? r_pge : '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;   r_e <= n_e;   r_j <= n_j;   r_mc <= n_mc;
        r_ins <= n_ins; r_hv <= n_hv; r_ovf <= n_ovf; r_done <= n_done; r_pgv <= n_pgv;
        r_ps <= n_ps; r_pe <= n_pe; r_ns <= n_ns; r_pgs <= n_pgs; r_pge <= n_pge;
        r_ogs <= n_ogs; r_oge <= n_oge; r_ogv <= n_ogv; r_olast <= n_olast;
        r_oovf <= n_oovf;
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_ov;
    assign o_gap_start      = r_ogs;
    assign o_gap_end        = r_oge;
    assign o_gap_valid      = r_ogv;
    assign o_last_result    = r_olast;
    assign o_table_overflow = r_oovf;
endmodule

// ===== sv/searched_range_set_top.sv =====
// Searched range set: top level with the table cell chains and sequencer.
// Sequence: a mark walks the table, pushes the merged ranges, loads them and realigns;
//   on overflow it skips the load; an inverted range goes straight to its result; a query
//   walks the whole table, then closes any open gap; output stalls hold either one.
// Items are taken one at a time; the input stalls while the cell chains are walked.
// Reset: synchronous, active low; clears the entry count and the handshake state.
`timescale 1ns / 1ps
module searched_range_set_top #(
    parameter int TABLE_DEPTH = srs_pkg::TABLE_DEPTH_DEF,
    parameter int POS_BITS    = srs_pkg::POS_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_func,
    input  logic [POS_BITS-1:0]  i_range_start,
    input  logic [POS_BITS-1:0]  i_range_end,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [POS_BITS-1:0]  o_gap_start,
    output logic [POS_BITS-1:0]  o_gap_end,
    output logic                 o_gap_valid,
    output logic                 o_last_result,
    output logic                 o_table_overflow
);
    import srs_pkg::*;

    t_chain_ctl ctl;
    logic [POS_BITS-1:0] a_start [TABLE_DEPTH];
    logic [POS_BITS-1:0] a_end   [TABLE_DEPTH];
    logic [POS_BITS-1:0] b_start [TABLE_DEPTH];
    logic [POS_BITS-1:0] b_end   [TABLE_DEPTH];
    logic [POS_BITS-1:0] b_tail_start, b_tail_end;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            if (g == TABLE_DEPTH - 1) begin : g_tail
                srs_cell #(.POS_BITS(POS_BITS)) u_a (
                    .i_clk(i_clk), .i_op(ctl.a_op),
                    .i_next_start(a_start[0]), .i_next_end(a_end[0]),
                    .i_load_start(b_start[g]), .i_load_end(b_end[g]),
                    .o_start(a_start[g]), .o_end(a_end[g])
                );
                srs_cell #(.POS_BITS(POS_BITS)) u_b (
                    .i_clk(i_clk), .i_op(ctl.b_op),
                    .i_next_start(b_tail_start), .i_next_end(b_tail_end),
                    .i_load_start(b_tail_start), .i_load_end(b_tail_end),
                    .o_start(b_start[g]), .o_end(b_end[g])
                );
            end else begin : g_body
                srs_cell #(.POS_BITS(POS_BITS)) u_a (
                    .i_clk(i_clk), .i_op(ctl.a_op),
                    .i_next_start(a_start[g+1]), .i_next_end(a_end[g+1]),
                    .i_load_start(b_start[g]), .i_load_end(b_end[g]),
                    .o_start(a_start[g]), .o_end(a_end[g])
                );
                srs_cell #(.POS_BITS(POS_BITS)) u_b (
                    .i_clk(i_clk), .i_op(ctl.b_op),
                    .i_next_start(b_start[g+1]), .i_next_end(b_end[g+1]),
                    .i_load_start(b_start[g+1]), .i_load_end(b_end[g+1]),
                    .o_start(b_start[g]), .o_end(b_end[g])
                );
            end
        end
    endgenerate

    srs_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .POS_BITS(POS_BITS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_func(i_func), .i_range_start(i_range_start), .i_range_end(i_range_end),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_gap_start(o_gap_start), .o_gap_end(o_gap_end), .o_gap_valid(o_gap_valid),
        .o_last_result(o_last_result), .o_table_overflow(o_table_overflow),
        .i_a0_start(a_start[0]), .i_a0_end(a_end[0]),
        .i_a1_start(a_start[1]), .i_a1_end(a_end[1]),
        .o_ctl(ctl), .o_b_start(b_tail_start), .o_b_end(b_tail_end)
    );

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input transfer did not make the block busy");

    a_push_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.b_op == CELL_SHIFT) |-> o_in_stall)
        else $error("merge chain written while idle");

    a_load_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.a_op == CELL_LOAD) |-> (ctl.b_op == CELL_HOLD))
        else $error("table load overlaps a merge push");

    a_chain_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (ctl.a_op == CELL_HOLD))
        else $error("table moved while idle");
endmodule

// ===== test/tb_top.sv =====
// Testbench for searched_range_set_top: table predictor, scoreboard, random traffic.
`timescale 1ns / 1ps
module tb_top;
    import srs_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int PW    = POS_BITS_DEF;
    localparam logic [PW-1:0] POS_TOP = {PW{1'b1}};
    localparam logic FUNC_MARK  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [PW-1:0] pos_t;
    typedef struct packed {
        pos_t gs;
        pos_t ge;
        logic gv;
        logic last;
        logic ovf;
    } gap_res_t;

    class range_scoreboard;
        pos_t tbl_s[DEPTH];
        pos_t tbl_e[DEPTH];
        int   tbl_n;
        gap_res_t pending[$];
        int   mismatches;

        function void clear();
            tbl_n = 0;
            pending.delete();
            mismatches = 0;
        endfunction

        function void add_expected(gap_res_t r);
            pending = {pending, r};
        endfunction

        function bit apply_mark(pos_t s, pos_t e);
            pos_t ls[DEPTH+1], le[DEPTH+1], ms[DEPTH+1], me[DEPTH+1];
            int p, j, mc;
            bit touch;
            p = tbl_n;
            j = 0;
            mc = 0;
            for (int i = tbl_n - 1; i >= 0; i--)
                if (tbl_s[i] > s || (tbl_s[i] == s && tbl_e[i] > e)) p = i;
            for (int i = 0; i <= tbl_n; i++) begin
                if (i == p) begin
                    ls[i] = s; le[i] = e;
                end else begin
                    ls[i] = tbl_s[j]; le[i] = tbl_e[j]; j++;
                end
            end
            for (int i = 0; i <= tbl_n; i++) begin
                if (mc > 0) begin
                    touch = (ls[i] == 0) || (ls[i] - 1 <= me[mc-1]);
                    if (touch && me[mc-1] < le[i]) begin
                        me[mc-1] = le[i];
                        continue;
                    end
                    if (ls[i] >= ms[mc-1] && le[i] <= me[mc-1]) continue;
                end
                ms[mc] = ls[i]; me[mc] = le[i]; mc++;
            end
            if (mc > DEPTH) return 1'b1;
            for (int i = 0; i < mc; i++) begin
                tbl_s[i] = ms[i]; tbl_e[i] = me[i];
            end
            tbl_n = mc;
            return 1'b0;
        endfunction

        function void note_transfer(logic f, pos_t s, pos_t e);
            gap_res_t r;
            pos_t pos;
            int i, k;
            bit done;
            if (f == FUNC_MARK) begin
                r = '0;
                r.last = 1'b1;
                if (s <= e) r.ovf = apply_mark(s, e);
                add_expected(r);
                return;
            end
            i = 0; k = 0; done = 0; pos = s;
            while (i < tbl_n && (tbl_s[i] < s || (tbl_s[i] == s && tbl_e[i] <= e))) i++;
            if (i > 0) i--;
            for (; i < tbl_n && !done && pos < e; i++) begin
                if (pos < tbl_s[i]) begin
                    r = '0; r.gv = 1'b1; r.gs = pos;
                    r.ge = (tbl_s[i] < e) ? tbl_s[i] : e;
                    add_expected(r); k++;
                end
                if (pos <= tbl_e[i]) begin
                    if (tbl_e[i] == POS_TOP) done = 1;
                    else pos = tbl_e[i] + 1;
                end
            end
            if (!done && i == tbl_n && pos < e) begin
                r = '0; r.gv = 1'b1; r.gs = pos; r.ge = e;
                add_expected(r); k++;
            end
            if (k == 0) begin
                r = '0;
                add_expected(r);
            end
            pending[pending.size()-1].last = 1'b1;
        endfunction

        function void check_result(gap_res_t got);
            gap_res_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_func = 1'b0;
    pos_t i_range_start = '0;
    pos_t i_range_end = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall, o_out_valid, o_gap_valid, o_last_result, o_table_overflow;
    pos_t o_gap_start, o_gap_end;

    range_scoreboard sb = new();
    int  cycles = 0;
    bit  quiet = 0;
    bit  hold_off = 0;

    searched_range_set_top dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_gap_start, o_gap_end, o_gap_valid, o_last_result,
                             o_table_overflow});
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_transfer(i_func, i_range_start, i_range_end);
    end

    // receiver stall pattern: random bursts, one long hold-off
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
                for (n = 0; n < 300; n++) @(posedge i_clk);
                hold_off = 0;
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 5);
                i_out_stall <= 1'b1;
                repeat (n - 1) @(posedge i_clk);
                @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send(logic f, pos_t s, pos_t e);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= f;
        i_range_start <= s;
        i_range_end <= e;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic pos_t rand_pos();
        return pos_t'({$urandom, $urandom} & POS_TOP);
    endfunction

    pos_t a, b;
    int kind;

    initial begin
        sb.clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty query, extremes, touching, full table, top entry
        send(FUNC_QUERY, 0, POS_TOP);
        send(FUNC_QUERY, 5, 5);
        send(FUNC_QUERY, 9, 3);
        send(FUNC_MARK, 9, 3);
        send(FUNC_MARK, 0, 0);
        send(FUNC_MARK, 1, 10);
        send(FUNC_MARK, 20, 30);
        send(FUNC_MARK, 31, 31);
        send(FUNC_QUERY, 0, 100);
        for (int i = 0; i < 16; i++) send(FUNC_MARK, 200 + 4 * i, 201 + 4 * i);
        send(FUNC_QUERY, 0, POS_TOP);
        send(FUNC_MARK, POS_TOP - 3, POS_TOP);
        send(FUNC_QUERY, 190, POS_TOP);
        drain();

        // hold-off while the sender keeps offering
        hold_off = 1;
        for (int i = 0; i < 10; i++) send(FUNC_QUERY, rand_pos(), rand_pos());
        drain();

        sb.tbl_n = sb.tbl_n;
        for (int it = 0; it < 142; it++) begin
            if (it == 120) quiet = 1;
            kind = $urandom_range(0, 9);
            if (it % 50 == 0) begin
                // restart with a fresh small table region is impossible; narrow ranges
            end
            if (kind < 6) begin
                a = (kind < 4) ? pos_t'($urandom_range(0, 2000)) : rand_pos();
                b = a + $urandom_range(0, 60);
                if (kind == 5 && $urandom_range(0, 1)) b = a - 1;
                send(FUNC_MARK, a, b);
            end else begin
                a = (kind < 9) ? pos_t'($urandom_range(0, 2000)) : rand_pos();
                b = (kind < 9) ? a + $urandom_range(0, 800) : rand_pos();
                send(FUNC_QUERY, a, b);
            end
        end
        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
